// ----- design/assert_macros.svh -----
// Assertion macros for the checker file.
// Each macro takes a label, an antecedent and a consequent; clock is clk, reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AST_IMPL(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define AST_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, also checked while reset is applied
`define AST_NEXT_ALWAYS(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) (ant) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/imufd_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the IMU deframer.
// No dependencies.
`timescale 1ns / 1ps

package imufd_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned WORD_W          = 16;
  localparam int unsigned NUM_WORDS       = 10;
  localparam int unsigned WORD_IDX_W      = $clog2(NUM_WORDS);
  localparam int unsigned FRAME_NUM_W     = 32;
  localparam int unsigned FRAME_COUNT_DEF = 32;
  localparam int unsigned OUT_DATA_W      = NUM_WORDS * WORD_W + FRAME_NUM_W;
  localparam int unsigned CFG_INDEX_W     = 8;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  localparam logic [7:0] HDR_A_RST = 8'hAA;
  localparam logic [7:0] HDR_B_RST = 8'hBB;
  localparam logic [7:0] TRL_A_RST = 8'hCC;
  localparam logic [7:0] TRL_B_RST = 8'hDD;

  localparam logic [CFG_INDEX_W-1:0] REG_HDR_A = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_HDR_B = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_TRL_A = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_TRL_B = CFG_INDEX_W'(3);

  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_CRC_ERR = 1'b1;

  // one classified byte in the queue
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              hdr_hit;
    logic              trl_hit;
  } item_t;

  // MSB-first CRC-16, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] x;
    x = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (x[15]) begin
        x = {x[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        x = {x[14:0], 1'b0};
      end
    end
    return x;
  endfunction

endpackage

// ----- design/imufd_front.sv -----
// Front end: configuration registers and byte classification against header/trailer values.
// Depends on imufd_pkg.
`timescale 1ns / 1ps

module imufd_front import imufd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]      cfg_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,
  output logic                   push_valid,
  output item_t                  push_item,
  input  logic                   push_ready
);

  logic [BYTE_W-1:0] hdr_a_r, hdr_b_r, trl_a_r, trl_b_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_a_r <= HDR_A_RST;
      hdr_b_r <= HDR_B_RST;
      trl_a_r <= TRL_A_RST;
      trl_b_r <= TRL_B_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HDR_A: hdr_a_r <= cfg_data;
        REG_HDR_B: hdr_b_r <= cfg_data;
        REG_TRL_A: trl_a_r <= cfg_data;
        REG_TRL_B: trl_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready          = push_ready;
  assign push_valid         = in_tvalid;
  assign push_item.data     = in_tdata;
  assign push_item.hdr_hit  = (in_tdata == hdr_a_r) || (in_tdata == hdr_b_r);
  assign push_item.trl_hit  = (in_tdata == trl_a_r) || (in_tdata == trl_b_r);

endmodule

// ----- design/imufd_queue.sv -----
// Short FIFO of classified bytes between front and back end.
// Depends on imufd_pkg.
`timescale 1ns / 1ps

module imufd_queue import imufd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  input  item_t push_item,
  output logic  push_ready,
  output logic  pop_valid,
  output item_t pop_item,
  input  logic  pop_ready
);

  item_t                  mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_PTR_W:0]   count_r;
  logic                   push, pop;

  assign push_ready = (count_r != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- design/imufd_back.sv -----
// Back end: frame state machine, word capture, CRC check and registered result.
// Depends on imufd_pkg.
`timescale 1ns / 1ps

module imufd_back import imufd_pkg::*; #(
  parameter int unsigned FRAME_COUNT_BITS = FRAME_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pop_valid,
  input  item_t                 pop_item,
  output logic                  pop_ready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  typedef enum logic [2:0] {
    S_HUNT,
    S_WORD,
    S_CRC_LO,
    S_CRC_HI,
    S_TRAILER
  } state_t;

  state_t                      state_r, state_nxt;
  logic [1:0]                  cnt_r, cnt_nxt;
  logic [WORD_IDX_W-1:0]       idx_r, idx_nxt;
  logic [BYTE_W-1:0]           hold_r, hold_nxt;
  logic [BYTE_W-1:0]           crc_lo_r, crc_lo_nxt;
  logic [15:0]                 crc_r, crc_nxt;
  logic [FRAME_COUNT_BITS-1:0] frames_r, frames_nxt;
  logic [WORD_W-1:0]           words_r [NUM_WORDS];
  logic                        word_wr;
  logic                        emit, emit_err;
  logic                        out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]       out_data_r;
  logic                        out_user_r;
  logic                        take;
  logic [1:0]                  cnt_inc;
  logic [NUM_WORDS*WORD_W-1:0] words_flat;

  assign pop_ready = !out_valid_r || out_tready;
  assign take      = pop_valid && pop_ready;
  assign cnt_inc   = cnt_r + 2'd1;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    hold_nxt   = hold_r;
    crc_lo_nxt = crc_lo_r;
    crc_nxt    = crc_r;
    frames_nxt = frames_r;
    word_wr    = 1'b0;
    emit       = 1'b0;
    emit_err   = 1'b0;
    if (take) begin
      case (state_r)
        S_WORD: begin
          crc_nxt = crc16_byte(crc_r, pop_item.data);
          if (cnt_r == 2'd0) begin
            hold_nxt = pop_item.data;
            cnt_nxt  = 2'd1;
          end else begin
            word_wr = 1'b1;
            cnt_nxt = 2'd0;
            if (idx_r == WORD_IDX_W'(NUM_WORDS - 1)) begin
              state_nxt = S_CRC_LO;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        end
        S_CRC_LO: begin
          crc_lo_nxt = pop_item.data;
          cnt_nxt    = 2'd0;
          state_nxt  = S_CRC_HI;
        end
        S_CRC_HI: begin
          cnt_nxt = 2'd0;
          if ({pop_item.data, crc_lo_r} != crc_r) begin
            emit      = 1'b1;
            emit_err  = 1'b1;
            state_nxt = S_HUNT;
          end else begin
            state_nxt = S_TRAILER;
          end
        end
        S_TRAILER: begin
          if (!pop_item.trl_hit) begin
            cnt_nxt = 2'd0;
          end else if (cnt_inc >= 2'd2) begin
            cnt_nxt    = 2'd0;
            emit       = 1'b1;
            frames_nxt = frames_r + 1'b1;
            state_nxt  = S_HUNT;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        default: begin
          state_nxt = S_HUNT;
          if (!pop_item.hdr_hit) begin
            cnt_nxt = 2'd0;
          end else if (cnt_inc >= 2'd2) begin
            cnt_nxt   = 2'd0;
            crc_nxt   = CRC_INIT;
            idx_nxt   = '0;
            state_nxt = S_WORD;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      words_flat[i*WORD_W +: WORD_W] = emit_err ? '0 : words_r[i];
    end
  end

  assign out_valid_nxt = (take && emit) ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (word_wr) begin
      words_r[idx_r] <= {hold_r, pop_item.data};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_HUNT;
      cnt_r       <= 2'd0;
      idx_r       <= '0;
      hold_r      <= '0;
      crc_lo_r    <= '0;
      crc_r       <= CRC_INIT;
      frames_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      hold_r      <= hold_nxt;
      crc_lo_r    <= crc_lo_nxt;
      crc_r       <= crc_nxt;
      frames_r    <= frames_nxt;
      out_valid_r <= out_valid_nxt;
      if (take && emit) begin
        out_data_r <= {FRAME_NUM_W'(frames_r), words_flat};
        out_user_r <= emit_err ? STATUS_CRC_ERR : STATUS_GOOD;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- design/imu_frame_deframer_crc16_core.sv -----
// Top level of the IMU frame deframer with CRC-16 check.
// out_tvalid is registered: it rises in the cycle after the back end takes the byte that completes a result.
// Accepts 1 byte per cycle; the 4-entry byte queue and the output register
// decouple input from a stalled result, so bytes stall only when the queue fills.
// Reset (rst_n, synchronous): hunts for a header, frame count zero, registers at defaults.
// Depends on imufd_pkg, imufd_front, imufd_queue, imufd_back.
`timescale 1ns / 1ps

module imu_frame_deframer_crc16_core import imufd_pkg::*; #(
  parameter int unsigned FRAME_COUNT_BITS = FRAME_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]      cfg_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // [7:0] rx_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [63:48] temperature,
  // [79:64] gyro_x, [95:80] gyro_y, [111:96] gyro_z, [127:112] mag_x,
  // [143:128] mag_y, [159:144] mag_z, [191:160] frame_number
  output logic [OUT_DATA_W-1:0]  out_tdata,
  output logic                   out_tuser   // [0] frame_status
);

  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;

  imufd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  imufd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  imufd_back #(
    .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- design/imufd_checker.sv -----
// Port-level checker for the IMU deframer result channel, bound to the top level.
// Depends on imufd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module imufd_checker import imufd_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  logic [NUM_WORDS*WORD_W-1:0] out_words;

  assign out_words = out_tdata[NUM_WORDS*WORD_W-1:0];

  `AST_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `AST_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser))
  `AST_NEXT_ALWAYS(a_reset_idle, !rst_n, !out_tvalid)
  `AST_IMPL(a_err_zero_words, out_tvalid && (out_tuser == STATUS_CRC_ERR), out_words == '0)

endmodule

bind imu_frame_deframer_crc16_core imufd_checker u_chk (.*);
